/* rtl/fct_pkg.sv */
// Shared constants, register map and pipeline control types for the frustum cull test.
package fct_pkg;

  localparam int MAX_PLANES_DEF  = 6;
  localparam int COORD_WIDTH_DEF = 16;

  // Plane registers that the configuration port can reach.
  localparam int CFG_PLANES = 6;

  // Normals are Q1.14.
  localparam int NORM_FRAC = 14;
  localparam int FIELD_W   = 16;
  localparam int PLANE_W   = 4 * FIELD_W;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_BASE  = 3'd1;

  localparam int PLANE_COUNT_W     = 3;
  localparam int PLANE_COUNT_RESET = 6;

  localparam int ACTION_W = 2;
  localparam logic [ACTION_W-1:0] ACT_BOX = 2'd0;

  // Field order inside a packed plane word.
  localparam int PF_NX = 0;
  localparam int PF_NY = 1;
  localparam int PF_NZ = 2;
  localparam int PF_D  = 3;

  // Load enables for the three lane stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } fct_adv_t;

  function automatic logic signed [FIELD_W-1:0] plane_field(logic [PLANE_W-1:0] p, int k);
    return $signed(p[k*FIELD_W +: FIELD_W]);
  endfunction

  function automatic logic [FIELD_W-1:0] abs_field(logic signed [FIELD_W-1:0] v);
    return v[FIELD_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

/* rtl/fct_plane_lane.sv */
// One plane of the cull test: products, sums, then the reject decision, one stage each.
module fct_plane_lane
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  fct_adv_t                      adv_i,
  input  logic [PLANE_W-1:0]            plane_i,
  input  logic                          box_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  input  logic [COORD_WIDTH-1:0]        ex_i,
  input  logic [COORD_WIDTH-1:0]        ey_i,
  input  logic [COORD_WIDTH-1:0]        ez_i,
  input  logic signed [COORD_WIDTH-1:0] r_i,
  output logic                          reject_o
);

  localparam int BaseW = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int SumW  = BaseW + 20;
  localparam int ProdW = COORD_WIDTH + FIELD_W;

  logic signed [FIELD_W-1:0] nx, ny, nz, dd;
  logic [FIELD_W-1:0]        nx_abs, ny_abs, nz_abs;
  logic signed [ProdW-1:0]   px, py, pz;
  logic [ProdW-1:0]          lx, ly, lz;
  logic signed [SumW-1:0]    r_lim;
  logic signed [SumW-1:0]    dist_d, lim_d, total;

  logic signed [SumW-1:0] px_q, py_q, pz_q;
  logic signed [SumW-1:0] lx_q, ly_q, lz_q;
  logic signed [SumW-1:0] dist_q, lim_q;
  logic                   reject_q;

  always_comb begin
    nx     = plane_field(plane_i, PF_NX);
    ny     = plane_field(plane_i, PF_NY);
    nz     = plane_field(plane_i, PF_NZ);
    dd     = plane_field(plane_i, PF_D);
    nx_abs = abs_field(nx);
    ny_abs = abs_field(ny);
    nz_abs = abs_field(nz);
    px     = cx_i * nx;
    py     = cy_i * ny;
    pz     = cz_i * nz;
    lx     = ex_i * nx_abs;
    ly     = ey_i * ny_abs;
    lz     = ez_i * nz_abs;
    r_lim  = SumW'(r_i) <<< NORM_FRAC;
    dist_d = px_q + py_q + pz_q - (SumW'(dd) <<< NORM_FRAC);
    lim_d  = lx_q + ly_q + lz_q;
    total  = dist_q + lim_q;
  end

  // Stage 1: products; any non-box shape carries radius in the first limit term.
  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      px_q <= SumW'(px);
      py_q <= SumW'(py);
      pz_q <= SumW'(pz);
      if (box_i) begin
        lx_q <= $signed(SumW'(lx));
        ly_q <= $signed(SumW'(ly));
        lz_q <= $signed(SumW'(lz));
      end else begin
        lx_q <= r_lim;
        ly_q <= '0;
        lz_q <= '0;
      end
    end
  end

  // Stage 2: signed distance and limit.
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      dist_q <= dist_d;
      lim_q  <= lim_d;
    end
  end

  // Stage 3: rejected when dist < -lim, i.e. dist + lim is negative.
  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      reject_q <= total[SumW-1];
    end
  end

  assign reject_o = reject_q;

endmodule

/* rtl/frustum_cull_test_core.sv */
// Top level of the frustum cull test: config registers, pipeline control and plane lanes.
//
// Usage: each item on the slave stream is one bounding shape. s_axis_tuser holds the
// shape kind (box, sphere, or point with expand margin); s_axis_tdata holds center,
// extents and radius. Each shape is tested against the first plane_count planes, and
// one result item leaves on the master stream: m_axis_tdata bit 0 is 1 when no enabled
// plane rejects the shape.
// Planes and plane_count are set through the APB port (64-bit registers at 8*index); the
// user must set them only while no item is in flight, and the block has no check for it.
// pready is always high and reads return register values. An accepted item loads the
// products on the accepting edge, then the sum, compare and output registers in turn.
// Throughput: one item per cycle while m_axis_tready is not held low; every plane has
// its own lane of multipliers, so all planes are tested in parallel.
// Stall: when the receiver holds m_axis_tready low, the output register holds its item
// and the stages behind it fill up; s_axis_tready drops only once all stages are full.
// Reset: all stages empty, plane_count is 6 and all planes are zero.
module frustum_cull_test_core
  import fct_pkg::*;
#(
  parameter int MAX_PLANES  = MAX_PLANES_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int InDataW    = ((7 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, center_z, extent_x, extent_y, extent_z, radius
  input  logic [InDataW-1:0]    s_axis_tdata,
  // action
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // inside_res
  output logic [7:0]            m_axis_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int W = COORD_WIDTH;

  logic [PLANE_COUNT_W-1:0] count_q;
  logic [PLANE_W-1:0]       plane_w [MAX_PLANES];
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_wr;

  logic     v1_q, v2_q, v3_q, vo_q;
  logic     rdy1, rdy2, rdy3, rdyo;
  logic     inside_q, inside_d;
  fct_adv_t adv;

  logic signed [W-1:0]    cx, cy, cz, ex, ey, ez, rr;
  logic [W-1:0]           ex_abs, ey_abs, ez_abs;
  logic                   box;
  logic [MAX_PLANES-1:0]  reject, enable;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= PLANE_COUNT_W'(PLANE_COUNT_RESET);
    end else if (cfg_wr && reg_idx == REG_PLANE_COUNT) begin
      count_q <= pwdata[PLANE_COUNT_W-1:0];
    end
  end

  for (genvar g = 0; g < MAX_PLANES; g++) begin : g_plane
    if (g < CFG_PLANES) begin : g_reg
      logic [PLANE_W-1:0] plane_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          plane_q <= '0;
        end else if (cfg_wr && reg_idx == REG_PLANE_BASE + REG_IDX_W'(g)) begin
          plane_q <= pwdata[PLANE_W-1:0];
        end
      end
      assign plane_w[g] = plane_q;
    end else begin : g_fixed
      assign plane_w[g] = '0;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_PLANE_COUNT) begin
      prdata = CFG_DATA_W'(count_q);
    end
    for (int g = 0; g < MAX_PLANES; g++) begin
      if (g < CFG_PLANES && reg_idx == REG_PLANE_BASE + REG_IDX_W'(g)) begin
        prdata = CFG_DATA_W'(plane_w[g]);
      end
    end
  end

  // ---------------- pipeline control ----------------
  assign rdyo = !vo_q || m_axis_tready;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign adv.s1 = rdy1 && s_axis_tvalid;
  assign adv.s2 = rdy2 && v1_q;
  assign adv.s3 = rdy3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // ---------------- item fields ----------------
  always_comb begin
    cx     = $signed(s_axis_tdata[0*W +: W]);
    cy     = $signed(s_axis_tdata[1*W +: W]);
    cz     = $signed(s_axis_tdata[2*W +: W]);
    ex     = $signed(s_axis_tdata[3*W +: W]);
    ey     = $signed(s_axis_tdata[4*W +: W]);
    ez     = $signed(s_axis_tdata[5*W +: W]);
    rr     = $signed(s_axis_tdata[6*W +: W]);
    // -min stays exact as an unsigned magnitude
    ex_abs = ex[W-1] ? (~ex + 1'b1) : ex;
    ey_abs = ey[W-1] ? (~ey + 1'b1) : ey;
    ez_abs = ez[W-1] ? (~ez + 1'b1) : ez;
    box    = (s_axis_tuser == ACT_BOX);
  end

  for (genvar g = 0; g < MAX_PLANES; g++) begin : g_lane
    fct_plane_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .plane_i (plane_w[g]),
      .box_i   (box),
      .cx_i    (cx),
      .cy_i    (cy),
      .cz_i    (cz),
      .ex_i    (ex_abs),
      .ey_i    (ey_abs),
      .ez_i    (ez_abs),
      .r_i     (rr),
      .reject_o(reject[g])
    );
  end

  // ---------------- result ----------------
  always_comb begin
    for (int g = 0; g < MAX_PLANES; g++) begin
      // counts above MAX_PLANES saturate because g never reaches it
      enable[g] = int'(count_q) > g;
    end
    inside_d = ~|(reject & enable);
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) begin
      inside_q <= inside_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {7'b0, inside_q};

  // ---------------- assertions ----------------
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q && !vo_q) |-> s_axis_tready)
    else $error("input stalled with an empty pipeline");

  a_drain_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdyo) |=> m_axis_tvalid)
    else $error("item lost between compare stage and output");

  a_no_planes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdyo && count_q == '0) |=> m_axis_tdata[0])
    else $error("shape rejected with no plane enabled");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the frustum cull test core: planes over APB, shapes streamed in.
module testbench;
  import fct_pkg::*;

  localparam int IN_W       = ((7 * COORD_WIDTH_DEF + 7) / 8) * 8;
  localparam int REG_STRIDE = 8;
  localparam int LATENCY    = 4;
  localparam longint NORM_ONE = longint'(1) << NORM_FRAC;

  localparam logic [ACTION_W-1:0] ACT_SPHERE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POINT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [15:0]         cx, cy, cz, ex, ey, ez, rad;
  } shape_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // center_x, center_y, center_z, extent_x, extent_y, extent_z, radius
  logic [IN_W-1:0]       s_axis_tdata = '0;
  // action
  logic [ACTION_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // inside_res
  logic [7:0]            m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  frustum_cull_test_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the plane registers
  logic [PLANE_COUNT_W-1:0] plane_cnt = PLANE_COUNT_W'(PLANE_COUNT_RESET);
  logic [PLANE_W-1:0]       plane_regs [MAX_PLANES_DEF] = '{default: '0};

  shape_t pending_shapes [$];
  bit     survive_q [$];
  int     shapes_sent;
  int     shapes_taken;
  int     results_seen;
  int     culled_cnt;
  int     error_cnt;
  int     setting_cnt;
  int     send_gap;
  int     stall_cnt;
  bit     calm;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Shape survives when no enabled plane puts it fully on the negative side.
  function automatic bit shape_survives(logic [ACTION_W-1:0] act, logic [IN_W-1:0] d);
    longint cx, cy, cz, ex, ey, ez, r;
    longint nx, ny, nz, dd, sdist, lim;
    int     n;
    bit     ok;
    ok = 1'b1;
    cx = $signed(d[15:0]);
    cy = $signed(d[31:16]);
    cz = $signed(d[47:32]);
    ex = mag($signed(d[63:48]));
    ey = mag($signed(d[79:64]));
    ez = mag($signed(d[95:80]));
    r  = $signed(d[111:96]);
    n  = plane_cnt > MAX_PLANES_DEF ? MAX_PLANES_DEF : int'(plane_cnt);
    for (int i = 0; i < n; i++) begin
      nx = $signed(plane_regs[i][15:0]);
      ny = $signed(plane_regs[i][31:16]);
      nz = $signed(plane_regs[i][47:32]);
      dd = $signed(plane_regs[i][63:48]);
      sdist = cx * nx + cy * ny + cz * nz - dd * NORM_ONE;
      if (act == ACT_BOX) lim = ex * mag(nx) + ey * mag(ny) + ez * mag(nz);
      else lim = r * NORM_ONE;
      if (sdist < -lim) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Stimulus driver
  always @(posedge clk_i) begin : drive
    shape_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        survive_q = {survive_q, shape_survives(s_axis_tuser, s_axis_tdata)};
        shapes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_shapes.size() > 0) begin
          nxt = pending_shapes.pop_front();
          s_axis_tdata  <= {nxt.rad, nxt.ez, nxt.ey, nxt.ex, nxt.cz, nxt.cy, nxt.cx};
          s_axis_tuser  <= nxt.act;
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i) begin : watch
    bit want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (survive_q.size() == 0) begin
          note_error($sformatf("result %0d with nothing expected", m_axis_tdata[0]));
        end else begin
          want = survive_q.pop_front();
          if (!want) culled_cnt++;
          if (m_axis_tdata[0] !== want)
            note_error($sformatf("inside_res expected %0d, got %0b", want, m_axis_tdata[0]));
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * REG_STRIDE);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PLANE_COUNT) plane_cnt = val[PLANE_COUNT_W-1:0];
    else plane_regs[idx - REG_PLANE_BASE] = val;
  endtask

  function automatic logic [PLANE_W-1:0] plane(int nx, int ny, int nz, int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  // Box-shaped view volume of half size w, one oblique far plane
  task automatic set_frustum(input int w, input int count);
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 0), plane(16384, 0, 0, -w));
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 1), plane(-16384, 0, 0, -w));
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 2), plane(0, -16384, 0, -w));
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 3), plane(0, 16384, 0, -w));
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 4), plane(-11585, 0, -11585, -w));
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 5), plane(0, 0, 16384, -w));
    reg_write(REG_PLANE_COUNT, CFG_DATA_W'(count));
    setting_cnt++;
  endtask

  // Random planes, the first two at the field extremes
  task automatic set_wild_planes(input int count);
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 0), plane(-32768, -32768, -32768, -32768));
    reg_write(REG_IDX_W'(REG_PLANE_BASE + 1), plane(32767, 32767, 32767, 32767));
    for (int i = 2; i < CFG_PLANES; i++)
      reg_write(REG_IDX_W'(REG_PLANE_BASE + i), {$urandom, $urandom});
    reg_write(REG_PLANE_COUNT, CFG_DATA_W'(count));
    setting_cnt++;
  endtask

  function automatic logic [15:0] rand_coord(int span);
    int v;
    case ($urandom_range(0, 15))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: begin
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic shape_t rand_shape(int span);
    shape_t s;
    int     k;
    k = $urandom_range(0, 15);
    s.act = k < 7 ? ACT_BOX : k < 11 ? ACT_SPHERE : k < 15 ? ACT_POINT : ACT_SPARE;
    s.cx  = rand_coord(span);
    s.cy  = rand_coord(span);
    s.cz  = rand_coord(span);
    s.ex  = rand_coord(span / 2);
    s.ey  = rand_coord(span / 2);
    s.ez  = rand_coord(span / 2);
    s.rad = rand_coord(span / 2);
    return s;
  endfunction

  function automatic shape_t mk(logic [ACTION_W-1:0] act, int cx, int cy, int cz,
                                int ex, int ey, int ez, int rad);
    shape_t s;
    s.act = act;
    s.cx = 16'(cx); s.cy = 16'(cy); s.cz = 16'(cz);
    s.ex = 16'(ex); s.ey = 16'(ey); s.ez = 16'(ez);
    s.rad = 16'(rad);
    return s;
  endfunction

  task automatic queue_shape(input shape_t s);
    pending_shapes = {pending_shapes, s};
    shapes_sent++;
  endtask

  task automatic queue_random(input int count, input int span);
    repeat (count) queue_shape(rand_shape(span));
  endtask

  // Wait until every item is accepted and every result checked, then let the pipe settle
  task automatic drain();
    while (shapes_taken != shapes_sent) @(posedge clk_i);
    while (results_seen < shapes_taken) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: six all-zero planes
    queue_random(12, 32767);
    drain();

    // Corner shapes against a view volume of half size 1000
    set_frustum(1000, 6);
    queue_shape(mk(ACT_BOX, 0, 0, 0, 0, 0, 0, 0));
    queue_shape(mk(ACT_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0));
    queue_shape(mk(ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767, -32768));
    queue_shape(mk(ACT_BOX, -1001, 0, 0, 0, 0, 0, 32767));
    queue_shape(mk(ACT_BOX, -1001, 0, 0, -1, 0, 0, 0));
    queue_shape(mk(ACT_SPHERE, -1001, 0, 0, 0, 0, 0, 1));
    queue_shape(mk(ACT_SPHERE, -1001, 0, 0, 32767, 32767, 32767, 0));
    queue_shape(mk(ACT_SPHERE, 0, 0, 0, 0, 0, 0, -32768));
    queue_shape(mk(ACT_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
    queue_shape(mk(ACT_POINT, 1000, 1000, -1000, 0, 0, 0, 0));
    queue_shape(mk(ACT_POINT, 1000, 1000, -1000, 0, 0, 0, -1));
    queue_shape(mk(ACT_POINT, 32767, -32768, 0, -32768, -32768, -32768, 32767));
    queue_shape(mk(ACT_SPARE, -1500, 0, 0, 0, 0, 0, 600));
    queue_shape(mk(ACT_SPARE, -1500, 0, 0, 0, 0, 0, 400));
    queue_shape(mk(ACT_SPARE, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
    queue_random(100, 2000);
    drain();

    // Count above the plane limit saturates
    set_wild_planes(7);
    queue_random(70, 32767);
    drain();

    // No plane enabled
    reg_write(REG_PLANE_COUNT, CFG_DATA_W'(0));
    setting_cnt++;
    queue_random(20, 32767);
    drain();

    set_wild_planes(5);
    queue_random(70, 32767);
    drain();

    // Last stretch without any idling
    calm = 1'b1;
    set_frustum($urandom_range(300, 3000), 3);
    queue_random(110, 3000);
    drain();

    if (survive_q.size() != 0)
      note_error($sformatf("%0d results never arrived", survive_q.size()));
    $display("Checked %0d shapes (%0d culled) over %0d plane settings, %0d errors.",
             results_seen, culled_cnt, setting_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("** frustum_cull_test_core: PASSED **");
    end else begin
      $display("** frustum_cull_test_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout: %0d of %0d items accepted, %0d results", shapes_taken, shapes_sent,
             results_seen);
    $display("** frustum_cull_test_core: FAILED **");
    $finish;
  end

endmodule
